// ===== rtl/satl_pkg.sv =====
// Shared types and constants for the set-associative tag lookup.
// No dependencies; imported by the front end, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package satl_pkg;

    localparam int ADDR_IN_W   = 32;
    localparam int CNT_W       = 32;
    localparam int OUT_WAY_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_back_state;

    // Back end to front end: dequeue strobe and clearing-pass status.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctrl;

    // Floor of log2; zero for inputs below two.
    function automatic int floor_log2(input longint v);
        longint x;
        int     n;
        x = v;
        n = 0;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/satl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module satl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/satl_front.sv =====
// Front end: accepts addresses, splits them into set index and tag, queues them.
// Depends on satl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module satl_front
    import satl_pkg::*;
#(
    parameter int AW       = 32,
    parameter int OFF_BITS = 6,
    parameter int IDX_BITS = 7,
    parameter int IDX_W    = 7,
    parameter int TAG_W    = 19,
    parameter int EXT_W    = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [ADDR_IN_W-1:0] i_address,
    output logic                      o_stall,
    output logic                      o_q_valid,
    output logic      [IDX_W-1:0]     o_q_index,
    output logic      [TAG_W-1:0]     o_q_tag,
    input  wire t_back_ctrl           i_back
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [EXT_W-1:0]  addr_ext;
    logic [IDX_W-1:0]  index;
    logic [TAG_W-1:0]  tag;
    logic              push;
    logic              pop;

    logic [IDX_W-1:0]  r_q_idx [QUEUE_DEPTH];
    logic [TAG_W-1:0]  r_q_tag [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    // Drop address bits above the configured address width.
    assign addr_ext = EXT_W'(i_address[AW-1:0]);

    generate
        if (IDX_BITS == 0) begin : g_one_set
            assign index = '0;
        end else begin : g_sets
            assign index = addr_ext[OFF_BITS +: IDX_W];
        end
    endgenerate

    assign tag = addr_ext[OFF_BITS + IDX_BITS +: TAG_W];

    assign o_stall = !i_rst_n || i_back.clearing || (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_back.pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_idx[r_wr_ptr] <= index;
            r_q_tag[r_wr_ptr] <= tag;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_index = r_q_idx[r_rd_ptr];
    assign o_q_tag   = r_q_tag[r_rd_ptr];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_count != '0))
        else $error("dequeue from empty queue");

endmodule

`default_nettype wire

// ===== rtl/satl_back.sv =====
// Back end: reads the set row, compares tags, fills on miss, counts, holds the result.
// Depends on satl_pkg and satl_ram.
`timescale 1ns / 1ps
`default_nettype none

module satl_back
    import satl_pkg::*;
#(
    parameter int WAYS  = 4,
    parameter int SETS  = 128,
    parameter int IDX_W = 7,
    parameter int TAG_W = 19
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire logic [IDX_W-1:0]     i_q_index,
    input  wire logic [TAG_W-1:0]     i_q_tag,
    output t_back_ctrl                o_ctrl,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit,
    output logic      [OUT_WAY_W-1:0] o_way,
    output logic      [CNT_W-1:0]     o_hit_total,
    output logic      [CNT_W-1:0]     o_miss_total
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (TAG_W + 1);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(SETS - 1);

    t_back_state      r_state, n_state;
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] r_idx;
    logic [TAG_W-1:0] r_tag;
    logic [CNT_W-1:0] r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0] r_miss_cnt, n_miss_cnt;

    logic                 r_out_valid;
    logic                 r_hit;
    logic [OUT_WAY_W-1:0] r_way;
    logic [CNT_W-1:0]     r_hit_total;
    logic [CNT_W-1:0]     r_miss_total;

    logic             out_free;
    logic             load_out;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ROW_W-1:0] ram_rdata;

    logic             hit;
    logic [WAY_W-1:0] found_way;
    logic [WAY_W-1:0] victim_way;
    logic [ROW_W-1:0] fill_row;

    // Row layout: per-way valid bits on top, then one tag per way.
    satl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (IDX_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_q_index),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_stall;

    // Compare every way; lowest matching way wins, lowest invalid way is the victim.
    always_comb begin
        logic [WAYS-1:0]  row_valid;
        logic [TAG_W-1:0] way_tag;
        row_valid  = ram_rdata[ROW_W-1 -: WAYS];
        hit        = 1'b0;
        found_way  = '0;
        victim_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            way_tag = ram_rdata[w*TAG_W +: TAG_W];
            if (row_valid[w] && (way_tag == r_tag)) begin
                hit       = 1'b1;
                found_way = WAY_W'(w);
            end
            if (!row_valid[w]) begin
                victim_way = WAY_W'(w);
            end
        end
        fill_row = ram_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == victim_way) begin
                fill_row[ROW_W - WAYS + w]   = 1'b1;
                fill_row[w*TAG_W +: TAG_W] = r_tag;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  n_state = (r_clr_addr == CLR_LAST) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:   n_state = i_q_valid ? ST_LOOKUP : ST_IDLE;
            ST_LOOKUP: n_state = out_free ? ST_IDLE : ST_LOOKUP;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = r_idx;
        ram_wdata       = fill_row;
        ram_re          = 1'b0;
        load_out        = 1'b0;
        o_ctrl.pop      = 1'b0;
        o_ctrl.clearing = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_ctrl.clearing = 1'b1;
                ram_we          = 1'b1;
                ram_waddr       = r_clr_addr;
                ram_wdata       = '0;
            end
            ST_IDLE: begin
                o_ctrl.pop = i_q_valid;
                ram_re     = i_q_valid;
            end
            ST_LOOKUP: begin
                load_out = out_free;
                ram_we   = out_free && !hit;
            end
            default: begin
                o_ctrl.clearing = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (load_out) begin
            if (hit) begin
                n_hit_cnt = (r_hit_cnt == CNT_MAX) ? r_hit_cnt : r_hit_cnt + CNT_W'(1);
            end else begin
                n_miss_cnt = (r_miss_cnt == CNT_MAX) ? r_miss_cnt : r_miss_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ctrl.pop) begin
            r_idx <= i_q_index;
            r_tag <= i_q_tag;
        end
        if (load_out) begin
            r_hit        <= hit;
            r_way        <= OUT_WAY_W'(hit ? found_way : victim_way);
            r_hit_total  <= n_hit_cnt;
            r_miss_total <= n_miss_cnt;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_way        = r_way;
    assign o_hit_total  = r_hit_total;
    assign o_miss_total = r_miss_total;

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.pop |-> i_q_valid)
        else $error("pop without a queued item");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != ST_IDLE))
        else $error("tag row written while idle");

    a_load_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_LOOKUP))
        else $error("result appeared without a lookup");

    a_one_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOOKUP) |=> ($stable(r_hit_cnt) && $stable(r_miss_cnt)))
        else $error("counter moved outside a lookup");

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_tag_lookup_core.sv =====
// Top level of the set-associative cache tag lookup.
// Depends on satl_pkg, satl_front, satl_back (which holds satl_ram).
`timescale 1ns / 1ps
`default_nettype none

// Each item is one byte address. The address is cut into line offset, set
// index and tag; the tag is compared against every valid way of the set. A
// match reports a hit and bumps the hit count; a miss fills the lowest invalid
// way (way 0 when the set is full) and bumps the miss count. Both counts
// saturate at all ones and the reported totals include the current access.
// The way field carries the low two bits of the way number. The front end
// takes an address into a two-entry queue, so it keeps accepting while the
// back end works or a result waits at the output, until the queue is full.
// The back end handles one item at a time, bound by the tag RAM: it pops an
// item and reads the set row, then compares and writes back the filled row,
// and pops no new item until the result is loaded into the output register.
// After reset the back end sweeps the tag RAM clear, one set per cycle
// (SETS sets, 128 at the default sizes), with o_stall held high until the
// sweep ends.
module set_assoc_cache_tag_lookup_core
    import satl_pkg::*;
#(
    parameter int CACHE_KB   = 32,
    parameter int LINE_BYTES = 64,
    parameter int WAYS       = 4,
    parameter int ADDR_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [ADDR_IN_W-1:0] i_address,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit,
    output logic      [OUT_WAY_W-1:0] o_way,
    output logic      [CNT_W-1:0]     o_hit_total,
    output logic      [CNT_W-1:0]     o_miss_total
);

    // Geometry: sizes that are not powers of two round down to one.
    localparam int AW         = (ADDR_BITS < ADDR_IN_W) ? ADDR_BITS : ADDR_IN_W;
    localparam longint SETS_RAW = (longint'(CACHE_KB) * 1024) / (longint'(LINE_BYTES) * WAYS);
    localparam longint SETS_ALLOC = (SETS_RAW > 0) ? SETS_RAW : 1;
    localparam int OFF_BITS   = floor_log2(longint'(LINE_BYTES));
    localparam int IDX_BITS   = floor_log2(SETS_ALLOC);
    localparam int SETS       = 1 << IDX_BITS;
    localparam int IDX_W      = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int TAG_W      = (AW > OFF_BITS + IDX_BITS) ? AW - OFF_BITS - IDX_BITS : 1;
    localparam int EXT_W      = OFF_BITS + IDX_BITS + TAG_W;

    logic             q_valid;
    logic [IDX_W-1:0] q_index;
    logic [TAG_W-1:0] q_tag;
    t_back_ctrl       back_ctrl;

    // Accept and split addresses; hold them in the queue until the back end pops.
    satl_front #(
        .AW       (AW),
        .OFF_BITS (OFF_BITS),
        .IDX_BITS (IDX_BITS),
        .IDX_W    (IDX_W),
        .TAG_W    (TAG_W),
        .EXT_W    (EXT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_address (i_address),
        .o_stall   (o_stall),
        .o_q_valid (q_valid),
        .o_q_index (q_index),
        .o_q_tag   (q_tag),
        .i_back    (back_ctrl)
    );

    // Look up, fill on miss, count, and hold the result until taken.
    satl_back #(
        .WAYS  (WAYS),
        .SETS  (SETS),
        .IDX_W (IDX_W),
        .TAG_W (TAG_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_index    (q_index),
        .i_q_tag      (q_tag),
        .o_ctrl       (back_ctrl),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

endmodule

`default_nettype wire

// ===== bench/set_assoc_cache_tag_lookup_core_test.sv =====
// Self-checking bench for set_assoc_cache_tag_lookup_core: directed and random
// addresses, checked result by result against an in-bench tag store model.
// Depends on rtl/satl_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_core_test;
    import satl_pkg::*;

    // Geometry at the default sizes: 128 sets of 4 ways, 64-byte lines.
    localparam int CACHE_KB   = 32;
    localparam int LINE_BYTES = 64;
    localparam int NUM_WAYS   = 4;
    localparam int ADDR_BITS  = 32;
    localparam int SETS       = CACHE_KB * 1024 / (LINE_BYTES * NUM_WAYS);
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int IDX_W      = $clog2(SETS);
    localparam int TAG_W      = ADDR_BITS - OFF_W - IDX_W;

    localparam int RANDOM_ITEMS = 1000;
    localparam int NUM_PHASES   = 4;
    // Cycles with no item moving on either side before the run is declared hung.
    // Covers the clearing pass after reset and long random stall stretches.
    localparam int HANG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
    } t_lookup_result;

    // Tracks the tag store and counters of the block, queues the predicted
    // lookup result for each accepted address and checks results in order.
    class lookup_scoreboard;
        bit                 line_valid [SETS][NUM_WAYS];
        bit [TAG_W-1:0]     line_tag   [SETS][NUM_WAYS];
        bit [CNT_W-1:0]     hit_count;
        bit [CNT_W-1:0]     miss_count;
        t_lookup_result     pending_lookups[$];
        int                 errors;
        int                 checked;
        int                 hits_seen;

        function void note_access(logic [ADDR_IN_W-1:0] addr);
            logic [IDX_W-1:0] set_idx;
            logic [TAG_W-1:0] tag;
            int               hit_way;
            int               fill_way;
            t_lookup_result   res;
            set_idx = addr[OFF_W +: IDX_W];
            tag     = addr[ADDR_BITS-1 -: TAG_W];
            hit_way  = -1;
            fill_way = 0;
            // Scan from the top so that the lowest matching way wins.
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag)
                    hit_way = w;
            end
            if (hit_way >= 0) begin
                if (hit_count != CNT_MAX)
                    hit_count++;
                res.hit = 1'b1;
                res.way = hit_way[OUT_WAY_W-1:0];
            end else begin
                if (miss_count != CNT_MAX)
                    miss_count++;
                // Lowest invalid way, or way 0 when the set is full.
                for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                    if (!line_valid[set_idx][w])
                        fill_way = w;
                end
                line_valid[set_idx][fill_way] = 1'b1;
                line_tag[set_idx][fill_way]   = tag;
                res.hit = 1'b0;
                res.way = fill_way[OUT_WAY_W-1:0];
            end
            res.hit_total  = hit_count;
            res.miss_total = miss_count;
            pending_lookups.push_back(res);
        endfunction

        function void check_lookup(t_lookup_result got);
            t_lookup_result want;
            if (pending_lookups.size() == 0) begin
                $error("result with no access pending: hit=%0b way=%0d", got.hit, got.way);
                errors++;
                return;
            end
            want = pending_lookups.pop_front();
            checked++;
            if (got.hit)
                hits_seen++;
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, got %0b", want.hit, got.hit);
                errors++;
            end
            if (got.way !== want.way) begin
                $error("way: expected %0d, got %0d", want.way, got.way);
                errors++;
            end
            if (got.hit_total !== want.hit_total) begin
                $error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
                errors++;
            end
            if (got.miss_total !== want.miss_total) begin
                $error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [ADDR_IN_W-1:0] i_address;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_hit;
    logic [OUT_WAY_W-1:0] o_way;
    logic [CNT_W-1:0]     o_hit_total;
    logic [CNT_W-1:0]     o_miss_total;

    lookup_scoreboard sb;

    // Pacing knobs, in percent of cycles.
    int send_idle_pct;
    int recv_stall_pct;
    int accepted_count;
    int quiet_cycles;

    // Random-part working set: a few hot sets and a pool of tags that is a bit
    // larger than the associativity, so sets fill, evict way 0 and hit.
    logic [IDX_W-1:0] hot_sets [4];
    logic [TAG_W-1:0] tag_pool [6];

    set_assoc_cache_tag_lookup_core #(
        .CACHE_KB   (CACHE_KB),
        .LINE_BYTES (LINE_BYTES),
        .WAYS       (NUM_WAYS),
        .ADDR_BITS  (ADDR_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_address    (i_address),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result side: stall at random per the current phase, updated on the
    // falling edge so the DUT sees a stable level at the rising edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: at each rising edge, record accepted addresses and check
    // accepted results. Also run the hang watchdog here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_access(i_address);
                accepted_count++;
                quiet_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                sb.check_lookup('{hit: o_hit, way: o_way,
                                  hit_total: o_hit_total, miss_total: o_miss_total});
                quiet_cycles = 0;
            end
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("Timed out: no item moved for %0d cycles, %0d lookups pending",
                         HANG_LIMIT, sb.pending_lookups.size());
                $display("set_assoc_cache_tag_lookup_core_test NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [ADDR_IN_W-1:0] pack_address(logic [TAG_W-1:0] tag,
                                                          logic [IDX_W-1:0] set_idx,
                                                          logic [OFF_W-1:0] offset);
        return {tag, set_idx, offset};
    endfunction

    // Present one address and hold it until accepted. Enter between items;
    // return at the rising edge that takes the item. Lower valid only while
    // idling, so a back-to-back item never sees valid dropped and raised.
    task automatic send_address(input logic [ADDR_IN_W-1:0] addr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_address <= addr;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // Draw a fresh set of hot sets and tags with random content.
    task automatic refresh_working_set();
        foreach (hot_sets[k])
            hot_sets[k] = IDX_W'($urandom_range(SETS - 1));
        foreach (tag_pool[k])
            tag_pool[k] = TAG_W'($urandom);
    endtask

    task automatic send_random_address();
        logic [ADDR_IN_W-1:0] addr;
        // Mostly reuse the working set to reach hits and full-set eviction;
        // the rest is scattered noise that exercises every address bit.
        if ($urandom_range(99) < 15)
            addr = $urandom;
        else
            addr = pack_address(tag_pool[$urandom_range(5)], hot_sets[$urandom_range(3)],
                                OFF_W'($urandom_range(LINE_BYTES - 1)));
        send_address(addr);
    endtask

    // Directed part: address extremes, offsets within one line, filling a
    // whole set, eviction of way 0 once the set is full, hits on every way.
    task automatic run_directed();
        logic [TAG_W-1:0] tag_a;
        logic [TAG_W-1:0] tag_b;
        logic [TAG_W-1:0] tag_c;
        logic [TAG_W-1:0] tag_d;
        logic [TAG_W-1:0] tag_e;
        tag_a = 19'h00123;
        tag_b = 19'h2A5A5;
        tag_c = 19'h55A5A;
        tag_d = 19'h7FFFE;
        tag_e = 19'h40001;
        send_address(32'h0000_0000);            // cold miss, way 0 of set 0
        send_address(32'h0000_003F);            // same line, top offset: hit
        send_address(32'hFFFF_FFFF);            // all ones: miss in the last set
        send_address(32'hFFFF_FFC0);            // same line, offset zero: hit
        // Fill set 5 through all four ways, then overflow it.
        send_address(pack_address(tag_a, 7'd5, 6'd0));
        send_address(pack_address(tag_b, 7'd5, 6'd1));
        send_address(pack_address(tag_c, 7'd5, 6'd2));
        send_address(pack_address(tag_d, 7'd5, 6'd3));
        send_address(pack_address(tag_e, 7'd5, 6'd4));   // full set: replace way 0
        send_address(pack_address(tag_b, 7'd5, 6'd63));  // hits on ways 1..3
        send_address(pack_address(tag_c, 7'd5, 6'd10));
        send_address(pack_address(tag_d, 7'd5, 6'd20));
        send_address(pack_address(tag_e, 7'd5, 6'd30));  // hit on way 0
        send_address(pack_address(tag_a, 7'd5, 6'd0));   // evicted tag misses again
        // Tag of all ones in set 0 lands in way 1 next to the zero tag.
        send_address(pack_address({TAG_W{1'b1}}, 7'd0, 6'd0));
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);
        send_address(32'h0000_0000);            // hit back in set 0
    endtask

    initial begin
        sb             = new;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_address      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        accepted_count = 0;
        quiet_cycles   = 0;

        // Hold reset, then release it on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Random part in four pacing phases: free running, sender gaps,
        // receiver stalls, then both.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                if (n % 100 == 0)
                    refresh_working_set();
                send_random_address();
            end
        end

        // Drop valid, drain every outstanding lookup, then idle a little
        // longer to catch any stray result.
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d addresses (%0d checked: %0d hits, %0d misses), with set",
                 accepted_count, sb.checked, sb.hits_seen, sb.checked - sb.hits_seen);
        $display("fill, way 0 replacement and four sender/receiver pacing mixes.");
        if (sb.errors == 0 && sb.pending_lookups.size() == 0) begin
            $display("set_assoc_cache_tag_lookup_core_test OK");
        end else begin
            $display("set_assoc_cache_tag_lookup_core_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/satl_pkg.sv
rtl/satl_ram.sv
rtl/satl_front.sv
rtl/satl_back.sv
rtl/set_assoc_cache_tag_lookup_core.sv
bench/set_assoc_cache_tag_lookup_core_test.sv
